### rtl/rc_packet_bind_and_hop_receiver_unit_defines.svh
// ----------------------------------------------------------------------------
// Bind and hop receiver assertion macros
// Shared property forms for the receiver checks.
// ----------------------------------------------------------------------------
`ifndef RC_PACKET_BIND_AND_HOP_RECEIVER_UNIT_DEFINES_SVH
`define RC_PACKET_BIND_AND_HOP_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RCBH_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCBH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rcbh_pkg.sv
// ----------------------------------------------------------------------------
// Bind and hop receiver package
// Word types, constants and bind sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcbh_pkg;

	localparam int HOP_COUNT   = 20;
	localparam int ADDR_BYTES  = 5;
	localparam int SEG_BYTES   = 7;
	localparam int LAST_BYTES  = 6;
	localparam int STAGE_BYTES = ADDR_BYTES + 2 * SEG_BYTES;
	localparam int QUEUE_DEPTH = 4;
	localparam int POS_W       = 5;
	localparam int SUM_W       = 11;

	localparam logic [7:0]  BIND_CHAN  = 8'h51;
	localparam logic [39:0] BIND_ADDR  = 40'h7845232312;
	localparam logic [39:0] RESET_ADDR = 40'hfd5a28bc04;
	localparam logic [7:0]  MARK0      = 8'hff;
	localparam logic [7:0]  MARK1      = 8'haa;
	localparam logic [7:0]  MARK2      = 8'h55;
	localparam logic [7:0]  STICK_MARK = 8'h55;
	localparam logic [7:0]  HOP_BASE   = 8'h02;
	localparam logic [7:0]  SEQ0       = 8'h00;
	localparam logic [7:0]  SEQ1       = 8'h01;
	localparam logic [7:0]  SEQ2       = 8'h02;

	typedef enum logic [1:0] {
		BS_MARKER,
		BS_HOPS0,
		BS_HOPS1,
		BS_HOPS2
	} bind_state_t;

	typedef struct packed {
		logic       bind_button;
		logic       packet_valid;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
		logic [7:0] byte5;
		logic [7:0] byte6;
		logic [7:0] byte7;
		logic [7:0] byte8;
		logic [7:0] byte9;
	} item_t;

	typedef struct packed {
		logic        in_bind_mode;
		logic        bind_complete;
		logic [7:0]  tune_channel;
		logic [39:0] tune_address;
		logic        pulse_update;
		logic [15:0] pulse_first;
		logic [15:0] pulse_second;
		logic [15:0] pulse_third;
	} result_t;

	typedef struct packed {
		logic        in_bind_mode;
		logic        bind_complete;
		logic [7:0]  tune_channel;
		logic [39:0] tune_address;
		logic        stick;
		logic [15:0] word0;
		logic [15:0] word1;
		logic [15:0] word2;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/rc_packet_bind_and_hop_receiver_unit.sv
// ----------------------------------------------------------------------------
// Bind and hop receiver
// Poll in, tune and pulse word out; bind sequencer, hop table, stick pulses.
// ----------------------------------------------------------------------------
// channel   handshake         word
// poll in   push / full       item   (rcbh_pkg::item_t)
// result    empty / pop       result (rcbh_pkg::result_t)
//
// One poll per cycle while full is low, one result word per poll, in order.
// A taken poll goes through the queue write, then the output register; it waits in the queue while a result is held.
// full rises only once QUEUE_DEPTH words wait behind a held result.
// Reset returns to run mode, hop index 0, default address and hop table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rc_packet_bind_and_hop_receiver_unit_defines.svh"

module rc_packet_bind_and_hop_receiver_unit #(
	parameter int QUEUE_DEPTH = rcbh_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire rcbh_pkg::item_t item,
	output logic                empty,
	input  wire logic           pop,
	output rcbh_pkg::result_t   result
);

	logic           cmd_push;
	rcbh_pkg::cmd_t cmd_in;
	rcbh_pkg::cmd_t cmd_out;
	logic           q_nonempty;
	logic           q_pop;

	rcbh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_full   (full),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	rcbh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cmd_push),
		.wdata    (cmd_in),
		.full     (full),
		.rd       (q_pop),
		.rdata    (cmd_out),
		.nonempty (q_nonempty)
	);

	rcbh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.cmd        (cmd_out),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	`RCBH_ASSERT_IMPLY(a_full_holds_result, full, !empty, "queue full with no result held")
	`RCBH_ASSERT_IMPLY(a_bind_tunes_bind_chan, !empty && result.in_bind_mode, (result.tune_channel == rcbh_pkg::BIND_CHAN) && (result.tune_address == rcbh_pkg::BIND_ADDR), "bind result not on bind channel")
	`RCBH_ASSERT_IMPLY(a_complete_leaves_bind, !empty && result.bind_complete, !result.in_bind_mode && !result.pulse_update, "bind completion still binding")
	`RCBH_ASSERT_NEXT(a_held_result_stable, !empty && !pop, !empty && $stable(result), "held result changed")

endmodule

`default_nettype wire

### rtl/rcbh_front.sv
// ----------------------------------------------------------------------------
// Bind and hop receiver front end
// Accept polls, run the bind sequencer, keep address and hop table, classify.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcbh_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          q_full,
	input  wire rcbh_pkg::item_t item,
	output logic               cmd_push,
	output rcbh_pkg::cmd_t     cmd
);

	localparam int HC = rcbh_pkg::HOP_COUNT;
	localparam int AB = rcbh_pkg::ADDR_BYTES;
	localparam int SB = rcbh_pkg::SEG_BYTES;
	localparam int LB = rcbh_pkg::LAST_BYTES;
	localparam int PW = rcbh_pkg::POS_W;
	localparam int SW = rcbh_pkg::SUM_W;

	rcbh_pkg::bind_state_t state_q, state_d;
	logic                  binding_q, binding_d;
	logic [SW-1:0]         sum_q, sum_d;
	logic [PW-1:0]         pos_q, pos_d;
	logic [39:0]           addr_q;
	logic [7:0]            hop_q [HC];
	logic [7:0]            stage_q [rcbh_pkg::STAGE_BYTES];
	logic [7:0]            pl [10];
	logic                  wr_addr, wr_seg0, wr_seg1, commit, stick;
	logic [39:0]           stage_addr;
	logic [7:0]            run_chan;

	assign pl[0] = item.byte0;
	assign pl[1] = item.byte1;
	assign pl[2] = item.byte2;
	assign pl[3] = item.byte3;
	assign pl[4] = item.byte4;
	assign pl[5] = item.byte5;
	assign pl[6] = item.byte6;
	assign pl[7] = item.byte7;
	assign pl[8] = item.byte8;
	assign pl[9] = item.byte9;

	assign cmd_push = push && !q_full;

	function automatic logic sum_ok(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [SW-1:0] s, input logic [7:0] seq);
		return (b0 == s[7:0]) && (b1 == {{(16 - SW){1'b0}}, s[SW-1:8]}) && (b2 == seq);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rcbh_pkg::BS_MARKER;
			binding_q <= 1'b0;
			sum_q     <= '0;
			pos_q     <= '0;
		end else begin
			state_q   <= state_d;
			binding_q <= binding_d;
			sum_q     <= sum_d;
			pos_q     <= pos_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		binding_d = binding_q;
		sum_d     = sum_q;
		pos_d     = pos_q;
		wr_addr   = 1'b0;
		wr_seg0   = 1'b0;
		wr_seg1   = 1'b0;
		commit    = 1'b0;
		stick     = 1'b0;
		if (cmd_push) begin
			if (!binding_q) begin
				if (item.bind_button) begin
					binding_d = 1'b1;
					state_d   = rcbh_pkg::BS_MARKER;
				end else if (item.packet_valid) begin
					if (pos_q >= PW'(HC - 1))
						pos_d = '0;
					else
						pos_d = pos_q + PW'(1);
					stick = (pl[7] == rcbh_pkg::STICK_MARK);
				end
			end else if (item.packet_valid) begin
				unique case (state_q)
					rcbh_pkg::BS_MARKER: begin
						if (pl[0] == rcbh_pkg::MARK0 && pl[1] == rcbh_pkg::MARK1 &&
								pl[2] == rcbh_pkg::MARK2) begin
							wr_addr = 1'b1;
							sum_d   = SW'(pl[3]) + SW'(pl[4]) + SW'(pl[5]) +
								SW'(pl[6]) + SW'(pl[7]);
							state_d = rcbh_pkg::BS_HOPS0;
						end
					end
					rcbh_pkg::BS_HOPS0: begin
						if (sum_ok(pl[0], pl[1], pl[2], sum_q, rcbh_pkg::SEQ0)) begin
							wr_seg0 = 1'b1;
							state_d = rcbh_pkg::BS_HOPS1;
						end
					end
					rcbh_pkg::BS_HOPS1: begin
						if (sum_ok(pl[0], pl[1], pl[2], sum_q, rcbh_pkg::SEQ1)) begin
							wr_seg1 = 1'b1;
							state_d = rcbh_pkg::BS_HOPS2;
						end
					end
					rcbh_pkg::BS_HOPS2: begin
						if (sum_ok(pl[0], pl[1], pl[2], sum_q, rcbh_pkg::SEQ2)) begin
							commit    = 1'b1;
							binding_d = 1'b0;
							pos_d     = '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_addr)
			for (int i = 0; i < AB; i++)
				stage_q[i] <= pl[3 + i];
		if (wr_seg0)
			for (int i = 0; i < SB; i++)
				stage_q[AB + i] <= pl[3 + i];
		if (wr_seg1)
			for (int i = 0; i < SB; i++)
				stage_q[AB + SB + i] <= pl[3 + i];
	end

	assign stage_addr = {stage_q[4], stage_q[3], stage_q[2], stage_q[1], stage_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= rcbh_pkg::RESET_ADDR;
			for (int i = 0; i < HC; i++)
				hop_q[i] <= rcbh_pkg::HOP_BASE + 8'(i);
		end else if (commit) begin
			addr_q <= stage_addr;
			for (int i = 0; i < HC - LB; i++)
				hop_q[i] <= stage_q[AB + i];
			for (int i = 0; i < LB; i++)
				hop_q[HC - LB + i] <= pl[3 + i];
		end
	end

	assign run_chan = (pos_d < PW'(HC)) ? hop_q[pos_d] : hop_q[0];

	always_comb begin
		cmd.in_bind_mode  = binding_d;
		cmd.bind_complete = commit;
		cmd.stick         = stick;
		cmd.word0         = {pl[1], pl[0]};
		cmd.word1         = {pl[3], pl[2]};
		cmd.word2         = {pl[5], pl[4]};
		if (binding_d) begin
			cmd.tune_channel = rcbh_pkg::BIND_CHAN;
			cmd.tune_address = rcbh_pkg::BIND_ADDR;
		end else if (commit) begin
			cmd.tune_channel = stage_q[AB];
			cmd.tune_address = stage_addr;
		end else begin
			cmd.tune_channel = run_chan;
			cmd.tune_address = addr_q;
		end
	end

endmodule

`default_nettype wire

### rtl/rcbh_queue.sv
// ----------------------------------------------------------------------------
// Bind and hop receiver command queue
// Short flip-flop queue between the front end and the pulse back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcbh_queue #(
	parameter int DEPTH = rcbh_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire rcbh_pkg::cmd_t wdata,
	output logic               full,
	input  wire logic          rd,
	output rcbh_pkg::cmd_t     rdata,
	output logic               nonempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rcbh_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= step(wr_ptr_q);
			if (rd)
				rd_ptr_q <= step(rd_ptr_q);
			if (wr && !rd)
				count_q <= count_q + CW'(1);
			else if (rd && !wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/rcbh_back.sv
// ----------------------------------------------------------------------------
// Bind and hop receiver back end
// Convert stick words to pulse widths and hold the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcbh_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_nonempty,
	input  wire rcbh_pkg::cmd_t cmd,
	output logic               q_pop,
	output logic               empty,
	input  wire logic          pop,
	output rcbh_pkg::result_t  result
);

	logic              valid_q;
	rcbh_pkg::result_t res_q;
	rcbh_pkg::result_t res_d;

	function automatic logic [15:0] to_pulse(input logic [15:0] w);
		logic [15:0] x;
		logic [17:0] t;
		x = ~w;
		t = {2'b00, x} + {1'b0, x, 1'b0};
		return t[17:2];
	endfunction

	assign q_pop  = q_nonempty && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = res_q;

	always_comb begin
		res_d.in_bind_mode  = cmd.in_bind_mode;
		res_d.bind_complete = cmd.bind_complete;
		res_d.tune_channel  = cmd.tune_channel;
		res_d.tune_address  = cmd.tune_address;
		res_d.pulse_update  = cmd.stick;
		res_d.pulse_first   = cmd.stick ? to_pulse(cmd.word0) : '0;
		res_d.pulse_second  = cmd.stick ? to_pulse(cmd.word1) : '0;
		res_d.pulse_third   = cmd.stick ? to_pulse(cmd.word2) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= res_d;
	end

endmodule

`default_nettype wire
